// ===== design/dptm_pkg.sv =====
package dptm_pkg;

  localparam int unsigned ChCount = 8;
  localparam int unsigned ChW     = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LockW   = 16;
  localparam int unsigned VelW    = 7;
  localparam int unsigned NoteW   = 7;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned PadW    = 6;
  localparam int unsigned PadIdxW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 24;

  localparam logic [CfgIdxW-1:0] RegLockout  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegVelocity = 1'b1;

  localparam logic [LockW-1:0] LockoutReset  = 16'd15;
  localparam logic [VelW-1:0]  VelocityReset = 7'd120;

  localparam logic [ChW-1:0] ChBass    = 3'd0;
  localparam logic [ChW-1:0] ChFloor1  = 3'd1;
  localparam logic [ChW-1:0] ChFloor2  = 3'd2;
  localparam logic [ChW-1:0] ChSnare   = 3'd3;
  localparam logic [ChW-1:0] ChCrash   = 3'd4;
  localparam logic [ChW-1:0] ChTom     = 3'd5;
  localparam logic [ChW-1:0] ChHihat   = 3'd6;
  localparam logic [ChW-1:0] ChRide    = 3'd7;
  localparam logic [ChW-1:0] ChLast    = ChRide;

  typedef struct packed {
    logic [VelW-1:0]  vel;
    logic [NoteW-1:0] note;
    logic [ChW-1:0]   ch;
  } result_t;

  function automatic logic [NoteW-1:0] note_of(input logic [ChW-1:0] ch);
    logic [NoteW-1:0] n;
    case (ch)
      ChBass:   n = 7'h24;
      ChFloor1: n = 7'h41;
      ChFloor2: n = 7'h43;
      ChSnare:  n = 7'h26;
      ChCrash:  n = 7'h4D;
      ChTom:    n = 7'h45;
      ChHihat:  n = 7'h32;
      ChRide:   n = 7'h3C;
      default:  n = 7'h24;
    endcase
    return n;
  endfunction

  function automatic logic [PadIdxW-1:0] pad_bit_of(input logic [ChW-1:0] ch);
    logic [PadIdxW-1:0] b;
    case (ch)
      ChBass:   b = 3'd0;
      ChFloor1: b = 3'd1;
      ChFloor2: b = 3'd2;
      ChTom:    b = 3'd3;
      ChHihat:  b = 3'd4;
      ChRide:   b = 3'd5;
      default:  b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic logic [VelW-1:0] snare_ladder(input logic [LevelW-1:0] lvl);
    logic [VelW-1:0] v;
    if (lvl > 12'd110) v = 7'd110;
    else if (lvl > 12'd100) v = 7'd100;
    else if (lvl > 12'd90) v = 7'd90;
    else if (lvl > 12'd80) v = 7'd80;
    else v = '0;
    return v;
  endfunction

  function automatic logic [VelW-1:0] crash_ladder(input logic [LevelW-1:0] lvl);
    logic [VelW-1:0] v;
    if (lvl > 12'd100) v = 7'd100;
    else if (lvl > 12'd90) v = 7'd90;
    else v = '0;
    return v;
  endfunction

endpackage

// ===== design/dptm_ram.sv =====
module dptm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/drum_pad_trigger_to_midi_unit.sv =====
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tdata: time_ms, pad_hits, snare, crash
// m_axis    out        tvalid/tready/tlast   tdata: channel, note, velocity
// cfg       in         cfg_we_i              cfg_index_i, cfg_wdata_i
//
// Each scan walks the eight channels, one per cycle while the output does not stall,
// through the last-hit RAM, and scans follow each other without a gap.
// Results leave one per cycle while the output does not stall. A result waits in the
// pending register until a later channel fires or the walk reaches the end.
// Reset clears the last-hit valid bits, so every channel starts at time zero.
// A stalled output holds the channel walk once the pending result cannot move.
module drum_pad_trigger_to_midi_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // From bit 0: time_ms[31:0], pad_hits[37:32], snare_level[49:38],
  // crash_level[61:50], zeros.
  input  logic [dptm_pkg::InDataW-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // From bit 0: channel_index[2:0], note_number[9:3], note_velocity[16:10],
  // zeros.
  output logic [dptm_pkg::OutDataW-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic cfg_we_i,
  input  logic [dptm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dptm_pkg::CfgW-1:0] cfg_wdata_i
);
  import dptm_pkg::*;

  logic [LockW-1:0] lockout_q;
  logic [VelW-1:0]  pad_vel_q;

  logic              scan_valid_q;
  logic [ChW-1:0]    a_ch_q;
  logic [TimeW-1:0]  scan_time_q;
  logic [PadW-1:0]   scan_pads_q;
  logic [LevelW-1:0] scan_snare_q;
  logic [LevelW-1:0] scan_crash_q;

  logic              b_valid_q;
  logic [ChW-1:0]    b_ch_q;
  logic [TimeW-1:0]  b_time_q;
  logic              b_active_q;
  logic [VelW-1:0]   b_vel_q;

  logic              pend_valid_q;
  logic              pend_closed_q;
  result_t           pend_q;

  logic              out_valid_q;
  logic              out_last_q;
  result_t           out_q;

  logic [ChCount-1:0] hit_valid_q;

  logic              in_acc;
  logic              adv;
  logic              a_active;
  logic [VelW-1:0]   a_vel;
  logic              ram_re;
  logic              ram_we;
  logic [TimeW-1:0]  ram_rdata;
  logic [TimeW-1:0]  last_hit;
  logic [TimeW-1:0]  deadline;
  logic              b_fire;
  logic              b_is_last;
  logic              b_ok;
  logic              b_step;
  logic              out_free;
  logic              pend_out;
  logic              pend_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LockoutReset;
      pad_vel_q <= VelocityReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLockout:  lockout_q <= cfg_wdata_i;
        RegVelocity: pad_vel_q <= cfg_wdata_i[VelW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  assign b_ok      = !b_valid_q || !pend_valid_q || out_free;
  assign adv       = b_ok;
  assign b_step    = b_valid_q && b_ok;
  assign s_axis_tready = !scan_valid_q || (adv && (a_ch_q == ChLast));
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (a_ch_q)
      ChSnare: begin
        a_vel    = snare_ladder(scan_snare_q);
        a_active = (a_vel != '0);
      end
      ChCrash: begin
        a_vel    = crash_ladder(scan_crash_q);
        a_active = (a_vel != '0);
      end
      default: begin
        a_vel    = pad_vel_q;
        a_active = scan_pads_q[pad_bit_of(a_ch_q)];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_valid_q <= 1'b0;
      a_ch_q       <= '0;
    end else if (in_acc) begin
      scan_valid_q <= 1'b1;
      a_ch_q       <= '0;
    end else if (adv && scan_valid_q) begin
      a_ch_q <= a_ch_q + 1'b1;
      if (a_ch_q == ChLast) begin
        scan_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scan_time_q  <= s_axis_tdata[31:0];
      scan_pads_q  <= s_axis_tdata[37:32];
      scan_snare_q <= s_axis_tdata[49:38];
      scan_crash_q <= s_axis_tdata[61:50];
    end
  end

  assign ram_re = adv && scan_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= scan_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      b_ch_q     <= a_ch_q;
      b_time_q   <= scan_time_q;
      b_active_q <= a_active;
      b_vel_q    <= a_vel;
    end
  end

  dptm_ram #(
    .Width(TimeW),
    .Depth(ChCount)
  ) u_last_hit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (b_ch_q),
    .wdata_i (b_time_q),
    .re_i    (ram_re),
    .raddr_i (a_ch_q),
    .rdata_o (ram_rdata)
  );

  assign last_hit  = hit_valid_q[b_ch_q] ? ram_rdata : '0;
  assign deadline  = last_hit + {{(TimeW-LockW){1'b0}}, lockout_q};
  assign b_fire    = b_active_q && (b_time_q > deadline);
  assign b_is_last = (b_ch_q == ChLast);
  assign ram_we    = b_step && b_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_valid_q <= '0;
    end else if (ram_we) begin
      hit_valid_q[b_ch_q] <= 1'b1;
    end
  end

  // The pending result learns whether it is the last one of its scan only when
  // a later channel fires or the walk reaches the last channel.
  assign pend_out  = pend_valid_q && out_free &&
                     (pend_closed_q || (b_step && (b_fire || b_is_last)));
  assign pend_last = pend_closed_q || (b_step && b_is_last && !b_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_closed_q <= 1'b0;
    end else if (ram_we) begin
      pend_valid_q  <= 1'b1;
      pend_closed_q <= b_is_last;
    end else if (pend_out) begin
      pend_valid_q  <= 1'b0;
      pend_closed_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      pend_q.ch   <= b_ch_q;
      pend_q.note <= note_of(b_ch_q);
      pend_q.vel  <= b_vel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pend_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_out) begin
      out_q      <= pend_q;
      out_last_q <= pend_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, out_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && ram_we) |-> (a_ch_q != b_ch_q))
    else $error("last-hit RAM read and write hit the same channel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_closed_q |-> pend_valid_q)
    else $error("closed pending result without a valid result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_out && !pend_last) |=> pend_valid_q)
    else $error("non-final result sent without a follower pending");

endmodule

// ===== bench/dptm_note_checker.sv =====
module dptm_note_checker
  import dptm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                scan_valid_i,
  input  logic                scan_ready_i,
  input  logic [InDataW-1:0]  scan_data_i,
  input  logic                note_valid_i,
  input  logic                note_ready_i,
  input  logic [OutDataW-1:0] note_data_i,
  input  logic                note_last_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  output int                  mismatches_o,
  output int                  notes_pending_o,
  output int                  notes_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 50;

  localparam logic [NoteW*ChCount-1:0] NoteTable =
    {7'h3C, 7'h32, 7'h45, 7'h4D, 7'h26, 7'h43, 7'h41, 7'h24};
  localparam logic [3*ChCount-1:0] PadTable =
    {3'd5, 3'd4, 3'd3, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0};

  typedef struct packed {
    logic [ChW-1:0]   ch;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
    logic             last;
  } note_msg_t;

  logic [TimeW-1:0] last_hit [ChCount];
  logic [LockW-1:0] lockout;
  logic [VelW-1:0]  pad_vel;
  note_msg_t        expected_notes [$];
  note_msg_t        want;

  function automatic logic [VelW-1:0] snare_velocity(input logic [LevelW-1:0] lvl);
    logic [VelW-1:0] v;
    v = '0;
    if (lvl > 12'd80) v = 7'd80;
    if (lvl > 12'd90) v = 7'd90;
    if (lvl > 12'd100) v = 7'd100;
    if (lvl > 12'd110) v = 7'd110;
    return v;
  endfunction

  function automatic logic [VelW-1:0] crash_velocity(input logic [LevelW-1:0] lvl);
    logic [VelW-1:0] v;
    v = '0;
    if (lvl > 12'd90) v = 7'd90;
    if (lvl > 12'd100) v = 7'd100;
    return v;
  endfunction

  task automatic predict_notes(input logic [InDataW-1:0] scan);
    logic [TimeW-1:0] now;
    logic [PadW-1:0]  pads;
    logic [VelW-1:0]  vel;
    logic             active;
    logic [TimeW-1:0] open_after;
    note_msg_t        msgs [ChCount];
    int               n;
    now  = scan[31:0];
    pads = scan[37:32];
    n    = 0;
    for (int ch = 0; ch < ChCount; ch++) begin
      if (ch == ChSnare) begin
        vel    = snare_velocity(scan[49:38]);
        active = (vel != '0);
      end else if (ch == ChCrash) begin
        vel    = crash_velocity(scan[61:50]);
        active = (vel != '0);
      end else begin
        vel    = pad_vel;
        active = pads[PadTable[ch*3 +: 3]];
      end
      // The lockout window closes on a 32-bit sum that may wrap.
      open_after = last_hit[ch] + {16'd0, lockout};
      if (active && now > open_after) begin
        last_hit[ch]   = now;
        msgs[n].ch     = 3'(ch);
        msgs[n].note   = NoteTable[ch*NoteW +: NoteW];
        msgs[n].vel    = vel;
        msgs[n].last   = 1'b0;
        n++;
      end
    end
    if (n > 0) msgs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_notes.push_back(msgs[i]);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches_o++;
      if (mismatches_o <= ReportLimit) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChCount; i++) last_hit[i] = '0;
      lockout = LockoutReset;
      pad_vel = VelocityReset;
      expected_notes.delete();
      mismatches_o    = 0;
      notes_checked_o = 0;
      notes_pending_o = 0;
    end else begin
      if (note_valid_i && note_ready_i) begin
        if (expected_notes.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit) begin
            $error("note request on channel %0d with none expected", note_data_i[2:0]);
          end
        end else begin
          want = expected_notes.pop_front();
          check_field("channel_index", want.ch, note_data_i[2:0]);
          check_field("note_number", want.note, note_data_i[9:3]);
          check_field("note_velocity", want.vel, note_data_i[16:10]);
          check_field("last_message", want.last, note_last_i);
          notes_checked_o++;
        end
      end
      if (scan_valid_i && scan_ready_i) predict_notes(scan_data_i);
      if (cfg_we_i) begin
        if (cfg_index_i == RegLockout) lockout = cfg_wdata_i[LockW-1:0];
        else if (cfg_index_i == RegVelocity) pad_vel = cfg_wdata_i[VelW-1:0];
      end
      notes_pending_o = expected_notes.size();
    end
  end

endmodule

// ===== bench/drum_pad_trigger_to_midi_unit_tb.sv =====
module drum_pad_trigger_to_midi_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dptm_pkg::*;

  localparam int StallLimit     = 2000;
  localparam int SettleCycles   = 24;
  localparam int HoldCycles     = 200;
  localparam int HoldAfterNotes = 150;
  localparam int PhaseItems     = 52;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_wdata_i;

  int               mismatches;
  int               notes_pending;
  int               notes_checked;
  int               scans_sent;
  int               settings_used;
  int               stall_cycles = 0;
  logic             steady_flow;
  logic [TimeW-1:0] now_ms;

  drum_pad_trigger_to_midi_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  dptm_note_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .scan_valid_i    (s_axis_tvalid),
    .scan_ready_i    (s_axis_tready),
    .scan_data_i     (s_axis_tdata),
    .note_valid_i    (m_axis_tvalid),
    .note_ready_i    (m_axis_tready),
    .note_data_i     (m_axis_tdata),
    .note_last_i     (m_axis_tlast),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mismatches_o    (mismatches),
    .notes_pending_o (notes_pending),
    .notes_checked_o (notes_checked)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int draw_gap();
    return steady_flow ? 0 : int'($urandom_range(3, 0));
  endfunction

  function automatic logic [LevelW-1:0] pick_level(input int lo, input int hi);
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return LevelW'($urandom_range(hi, lo));
    if (r < 75) return LevelW'($urandom_range(4095, 0));
    return LevelW'($urandom_range(lo, 0));
  endfunction

  task automatic send_scan(input logic [TimeW-1:0] t, input logic [PadW-1:0] pads,
                           input logic [LevelW-1:0] snare, input logic [LevelW-1:0] crash);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, crash, snare, pads, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    scans_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (notes_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_scan(input logic [LockW-1:0] lock);
    int              r;
    logic [PadW-1:0] pads;
    r = $urandom_range(99, 0);
    if (r < 80) now_ms += $urandom_range(2 * lock + 2, 0);
    else if (r < 88) now_ms = $urandom();
    else if (r < 94) now_ms = 32'hFFFF_FFFF - $urandom_range(lock + 4, 0);
    else now_ms -= $urandom_range(lock + 1, 0);
    r = $urandom_range(99, 0);
    if (r < 10) pads = '0;
    else if (r < 20) pads = '1;
    else pads = PadW'($urandom());
    send_scan(now_ms, pads, pick_level(78, 113), pick_level(88, 103));
  endtask

  task automatic run_phase(input logic [LockW-1:0] lock, input logic [CfgW-1:0] vel_word);
    wait_idle();
    write_reg(RegLockout, lock);
    write_reg(RegVelocity, vel_word);
    settings_used++;
    for (int i = 0; i < PhaseItems; i++) begin
      steady_flow = (i >= 20 && i < 36);
      random_scan(lock);
    end
    steady_flow = 1'b0;
  endtask

  task automatic directed_scans();
    send_scan(32'd0, '1, 12'hFFF, 12'hFFF);
    send_scan(32'd15, '1, 12'hFFF, 12'hFFF);
    send_scan(32'd16, '1, 12'hFFF, 12'hFFF);
    send_scan(32'd31, '1, 12'hFFF, 12'hFFF);
    send_scan(32'd32, '0, 12'd111, 12'd101);
    send_scan(32'd100, '0, 12'd110, 12'd100);
    send_scan(32'd200, '0, 12'd101, 12'd91);
    send_scan(32'd300, '0, 12'd100, 12'd90);
    send_scan(32'd400, '0, 12'd91, 12'd0);
    send_scan(32'd500, '0, 12'd90, 12'd0);
    send_scan(32'd600, '0, 12'd81, 12'd0);
    send_scan(32'd700, '0, 12'd80, 12'd0);
    for (int i = 0; i < PadW; i++) begin
      send_scan(32'd1000 + 32'd100 * i, PadW'(1 << i), 12'd0, 12'd0);
    end
    // The stored hit time near the top makes the lockout sum wrap, so time 10 fires early.
    send_scan(32'hFFFF_FFF8, '1, 12'hFFF, 12'hFFF);
    send_scan(32'd3, '1, 12'hFFF, 12'hFFF);
    send_scan(32'd10, '1, 12'hFFF, 12'hFFF);
    send_scan(32'hFFFF_FFFF, '1, 12'hFFF, 12'hFFF);
    now_ms = 32'hFFFF_FFFF;
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Watchdog: no request accepted for %0d cycles.", stall_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : receiver
    int gap;
    int taken;
    m_axis_tready = 1'b0;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
      if (taken == HoldAfterNotes) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegLockout;
    cfg_wdata_i   = '0;
    steady_flow   = 1'b0;
    now_ms        = '0;
    scans_sent    = 0;
    settings_used = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_scans();
    run_phase(16'd0, 16'hFFFF);
    run_phase(16'hFFFF, 16'd0);
    run_phase(LockW'($urandom_range(40, 1)), CfgW'($urandom()));
    run_phase(LockW'($urandom()), CfgW'($urandom()));
    run_phase(16'd15, 16'd1);
    wait_idle();

    $display("Ran %0d scans over %0d register settings and compared %0d notes in order.",
             scans_sent, settings_used, notes_checked);
    $display("Lockout wrap, every ladder rung, velocity masking and a long output stall were hit.");
    if (mismatches == 0 && notes_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dptm_pkg.sv
design/dptm_ram.sv
design/drum_pad_trigger_to_midi_unit.sv
bench/dptm_note_checker.sv
bench/drum_pad_trigger_to_midi_unit_tb.sv
